@@ src/rir_pkg.sv @@
// Shared constants, types and helpers for the right-angle frame rotator.
// No dependencies; every other file of the rotator but rir_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package rir_pkg;

  // Frame geometry
  localparam int MaxSide   = 64;
  localparam int MaxPixels = 4096;
  localparam int SideW     = $clog2(MaxSide);        // row / column index
  localparam int AddrW     = $clog2(MaxPixels);      // frame store address
  localparam int CntW      = $clog2(MaxPixels + 1);  // pixel counters
  localparam int IdxW      = 2 * SideW + 2;          // row * width + column

  // Item and configuration widths
  localparam int PixelW  = 32;
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 2;

  // Item kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_mode_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // load item accepted
    logic read;     // read item accepted on a complete frame: fetch pixel
    logic capture;  // store read data is valid: fill the output register
  } rir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_full;  // every pixel of the current frame is loaded
    logic out_free;    // output register is empty or drains this cycle
  } rir_status_t;

  // Side length clamped to 1..MaxSide
  function automatic logic [SideW:0] clamp_side(input logic [CfgW-1:0] v);
    logic [SideW:0] res;
    if (v == '0) begin
      res = (SideW + 1)'(1);
    end else if (v > CfgW'(MaxSide)) begin
      res = (SideW + 1)'(MaxSide);
    end else begin
      res = (SideW + 1)'(v);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/rir_in_if.sv @@
// Input channel of the rotator: valid/ready handshake with kind and pixel.
// Depends on rir_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rir_in_if;
  import rir_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [PixelW-1:0] pixel_in;

  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface
`default_nettype wire

@@ src/rir_out_if.sv @@
// Output channel of the rotator: valid/ready handshake with pixel and last flag.
// Depends on rir_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rir_out_if;
  import rir_pkg::*;

  logic              valid;
  logic              ready;
  logic [PixelW-1:0] pixel_out;
  logic              last_pixel;

  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface
`default_nettype wire

@@ src/rir_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rir_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/rir_ctrl.sv @@
// Rotator controller: accepts items and sequences the store read of a read item.
// Depends on rir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rir_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_kind_i,
  output logic                      in_ready_o,
  input  wire rir_pkg::rir_status_t status_i,
  output rir_pkg::rir_cmd_t         cmd_o
);
  import rir_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        accept;

  // Take an item only when a read result would find the output register free
  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Commands and next state
  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.read    = 1'b0;
    cmd_o.capture = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_kind_i == KindLoad) begin
          cmd_o.load = 1'b1;
        end
        // an early read is consumed without a result
        if (accept && in_kind_i == KindRead && status_i.frame_full) begin
          cmd_o.read = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ src/rir_datapath.sv @@
// Rotator datapath: configuration registers, counters, address mapping,
// frame store and output register. Depends on rir_pkg and rir_ram.
`timescale 1ns / 1ps
`default_nettype none
module rir_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rir_pkg::CfgW-1:0]      cfg_wdata_i,
  input  wire logic [rir_pkg::PixelW-1:0]    pixel_in_i,
  input  wire rir_pkg::rir_cmd_t             cmd_i,
  output rir_pkg::rir_status_t               status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rir_pkg::PixelW-1:0]    pixel_out_o,
  output logic                               last_pixel_o
);
  import rir_pkg::*;

  logic [CfgW-1:0]   width_q, height_q;
  rot_mode_e         mode_q;
  logic [CntW-1:0]   load_count_q, load_count_d;
  logic [CntW-1:0]   out_row_q, out_row_d;
  logic [SideW-1:0]  out_col_q, out_col_d;
  logic [CntW-1:0]   out_count_q, out_count_d;
  logic              last_pend_q, oob_pend_q;
  logic              out_valid_q;
  logic [PixelW-1:0] pixel_out_q;
  logic              last_pixel_q;

  logic [SideW:0]     w, h, ow, oh;
  logic [2*SideW+1:0] area;
  logic [CntW-1:0]    total;
  logic [SideW-1:0]   r, c, sr, sc;
  logic [IdxW-1:0]    idx;
  logic               frame_full, last, store_we;
  logic [PixelW-1:0]  rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(1);
      height_q <= CfgW'(1);
      mode_q   <= ROT_0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        CFG_MODE:   mode_q   <= rot_mode_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // Geometry of the frame and of the rotated output
  assign w     = clamp_side(width_q);
  assign h     = clamp_side(height_q);
  assign area  = w * h;
  assign total = CntW'(area);
  assign ow    = mode_q[0] ? h : w;
  assign oh    = mode_q[0] ? w : h;

  assign frame_full = load_count_q >= total;
  assign last       = (out_count_q + CntW'(1)) >= total;

  // Output position, clamped to the current output size
  assign r = (out_row_q < CntW'(oh)) ? out_row_q[SideW-1:0] : SideW'(oh - 1'b1);
  assign c = ({1'b0, out_col_q} < ow) ? out_col_q : SideW'(ow - 1'b1);

  // Map the output position back to the source pixel
  always_comb begin
    case (mode_q)
      ROT_90: begin
        sr = SideW'(h - 1'b1 - {1'b0, c});
        sc = r;
      end
      ROT_180: begin
        sr = SideW'(h - 1'b1 - {1'b0, r});
        sc = SideW'(w - 1'b1 - {1'b0, c});
      end
      ROT_270: begin
        sr = c;
        sc = SideW'(w - 1'b1 - {1'b0, r});
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
  end

  assign idx = IdxW'(sr * w) + IdxW'(sc);

  // Counter updates
  always_comb begin
    load_count_d = load_count_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_count_d  = out_count_q;
    if (cmd_i.load && !frame_full) begin
      load_count_d = load_count_q + CntW'(1);
    end
    if (cmd_i.read) begin
      if (last) begin
        load_count_d = '0;
        out_row_d    = '0;
        out_col_d    = '0;
        out_count_d  = '0;
      end else begin
        out_count_d = out_count_q + CntW'(1);
        if (({1'b0, out_col_q} + 1'b1) >= ow) begin
          out_col_d = '0;
          out_row_d = out_row_q + CntW'(1);
        end else begin
          out_col_d = out_col_q + SideW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_count_q  <= '0;
    end else begin
      load_count_q <= load_count_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
      out_count_q  <= out_count_d;
    end
  end

  // Frame store; pixels past the store size are counted but dropped
  assign store_we = cmd_i.load && !frame_full && (load_count_q < CntW'(MaxPixels));

  rir_ram #(
    .Width (PixelW),
    .Depth (MaxPixels)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (load_count_q[AddrW-1:0]),
    .wdata_i (pixel_in_i),
    .re_i    (cmd_i.read),
    .raddr_i (idx[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Flags that travel alongside the store read
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      last_pend_q <= last;
      oob_pend_q  <= idx >= IdxW'(MaxPixels);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.capture) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pixel_out_q  <= oob_pend_q ? '0 : rdata;
      last_pixel_q <= last_pend_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign last_pixel_o = last_pixel_q;

  assign status_o.frame_full = frame_full;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

@@ src/image_rotator_right_angles_top.sv @@
// Right-angle frame rotator. A load item, or a read that comes before the frame is complete,
// is handled when it is accepted; any other read issues the store read when the item is
// accepted, and the registered store data fills the output register in the next cycle; no
// new item is taken until then. No item is taken while a result waits unread.
// Reset clears counters, configuration and the output valid flag at once; the frame store
// and the output pixel are not cleared and hold no reset value.
`timescale 1ns / 1ps
`default_nettype none
module image_rotator_right_angles_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rir_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rir_pkg::CfgW-1:0]    cfg_wdata_i,
  rir_in_if.sink                           in_i,
  rir_out_if.source                        out_o
);
  import rir_pkg::*;

  rir_cmd_t    cmd;
  rir_status_t status;

  // Controller
  rir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  rir_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pixel_in_i   (in_i.pixel_in),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .pixel_out_o  (out_o.pixel_out),
    .last_pixel_o (out_o.last_pixel)
  );

  // A capture always follows a store read issued in the previous cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> $past(cmd.read))
    else $error("capture without a pending store read");

  // A store read always produces a valid result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.read |=> ##1 out_o.valid)
    else $error("store read did not fill the output register");

  // No item is taken while a store read is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> !in_i.ready)
    else $error("item accepted during a pending store read");

  // The output register is never overwritten while it still holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> !out_o.valid)
    else $error("output register overwritten before it was taken");

endmodule
`default_nettype wire

@@ sim/tb_image_rotator_right_angles_top.sv @@
// Testbench for the right-angle frame rotator: loads frames, reads them back
// turned by every mode and checks each pixel against an in-bench predictor.
// Depends on rir_pkg, rir_in_if, rir_out_if and image_rotator_right_angles_top.
`timescale 1ns / 1ps
module tb_image_rotator_right_angles_top;
  import rir_pkg::*;

  localparam int unsigned MaxGap       = 10;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned QuietLimit   = 400;
  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned AreaCap      = 256;
  // Index past the last register; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [PixelW-1:0] pixel;
  } pixel_item_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              last;
  } rot_pixel_t;

  // Clock, reset and driven inputs, all known from time zero
  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = CFG_WIDTH;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_kind   = KindLoad;
  logic [PixelW-1:0]  in_pixel  = '0;
  logic               out_ready = 1'b0;

  rir_in_if  pix_in_bus ();
  rir_out_if pix_out_bus ();

  assign pix_in_bus.valid    = in_valid;
  assign pix_in_bus.kind     = in_kind;
  assign pix_in_bus.pixel_in = in_pixel;
  assign pix_out_bus.ready   = out_ready;

  image_rotator_right_angles_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (pix_in_bus),
    .out_o      (pix_out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: shadow registers, frame copy and read position
  logic [CfgW-1:0]   width_reg  = CfgW'(1);
  logic [CfgW-1:0]   height_reg = CfgW'(1);
  rot_mode_e         mode_reg   = ROT_0;
  logic [PixelW-1:0] frame_copy [MaxPixels];
  int unsigned       frame_loaded;
  int unsigned       row_pos;
  int unsigned       col_pos;
  int unsigned       pix_count;

  pixel_item_t pixel_items_pending [$];
  rot_pixel_t  rotated_pixels_due  [$];

  bit          in_burst;
  bit          out_burst;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned loads_taken;
  int unsigned reads_taken;
  int unsigned pixels_checked;
  int unsigned frames_checked;
  int unsigned phases_run;

  function automatic int unsigned side_len(input logic [CfgW-1:0] raw);
    if (raw == '0) return 1;
    if (raw > CfgW'(MaxSide)) return MaxSide;
    return int'(raw);
  endfunction

  function automatic int unsigned draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Expected effect of one accepted item: store a pixel or emit the next one
  function automatic void predict_rotated_pixel(input pixel_item_t it);
    int unsigned w, h, total, ow, oh, r, c, sr, sc, idx;
    rot_pixel_t  res;
    w     = side_len(width_reg);
    h     = side_len(height_reg);
    total = w * h;
    ow    = (mode_reg == ROT_90 || mode_reg == ROT_270) ? h : w;
    oh    = (mode_reg == ROT_90 || mode_reg == ROT_270) ? w : h;
    if (it.kind == KindLoad) begin
      if (frame_loaded < total) begin
        if (frame_loaded < MaxPixels) frame_copy[frame_loaded] = it.pixel;
        frame_loaded++;
      end
      return;
    end
    // read before the frame is complete: no pixel
    if (frame_loaded < total) return;
    r = (row_pos < oh) ? row_pos : oh - 1;
    c = (col_pos < ow) ? col_pos : ow - 1;
    case (mode_reg)
      ROT_90: begin
        sr = h - 1 - c;
        sc = r;
      end
      ROT_180: begin
        sr = h - 1 - r;
        sc = w - 1 - c;
      end
      ROT_270: begin
        sr = c;
        sc = w - 1 - r;
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
    idx       = sr * w + sc;
    res.pixel = (idx < MaxPixels) ? frame_copy[idx] : '0;
    res.last  = (pix_count + 1 >= total);
    if (res.last) begin
      frame_loaded = 0;
      row_pos      = 0;
      col_pos      = 0;
      pix_count    = 0;
    end else begin
      pix_count++;
      if (col_pos + 1 >= ow) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    end
    rotated_pixels_due.push_back(res);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Input driver: one item from the pending queue, random gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin : drive
      pixel_item_t nxt;
      pixel_item_t cur;
      bit          taken;
      int unsigned gap_now;
      taken   = in_valid && pix_in_bus.ready;
      gap_now = in_gap;
      if (taken) begin
        cur.kind  = in_kind;
        cur.pixel = in_pixel;
        predict_rotated_pixel(cur);
        if (in_kind == KindLoad) loads_taken++;
        else reads_taken++;
        gap_now = draw_gap(in_burst);
      end
      if (taken || !in_valid) begin
        if (gap_now != 0) begin
          in_valid <= 1'b0;
          in_gap   <= gap_now - 1;
        end else if (pixel_items_pending.size() != 0) begin
          nxt = pixel_items_pending.pop_front();
          in_valid <= 1'b1;
          in_kind  <= nxt.kind;
          in_pixel <= nxt.pixel;
          in_gap   <= 0;
        end else begin
          in_valid <= 1'b0;
          in_gap   <= 0;
        end
      end
    end
  end

  // Output monitor: compare each pixel with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin : watch
      rot_pixel_t  want;
      int unsigned hold;
      if (out_ready && pix_out_bus.valid) begin
        if (rotated_pixels_due.size() == 0) begin
          flag_mismatch($sformatf("pixel %h with nothing expected", pix_out_bus.pixel_out));
        end else begin
          want = rotated_pixels_due.pop_front();
          pixels_checked++;
          if (want.last) frames_checked++;
          if (pix_out_bus.pixel_out !== want.pixel)
            flag_mismatch($sformatf("pixel_out %h, expected %h",
                                    pix_out_bus.pixel_out, want.pixel));
          if (pix_out_bus.last_pixel !== want.last)
            flag_mismatch($sformatf("last_pixel %b, expected %b",
                                    pix_out_bus.last_pixel, want.last));
        end
        hold = draw_gap(out_burst);
        out_stall <= hold;
        out_ready <= (hold == 0);
      end else if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= (out_stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && pix_in_bus.ready) || (out_ready && pix_out_bus.valid) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("timeout: no item moved for %0d cycles", QuietLimit);
      $display("tb_image_rotator_right_angles_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_load(input logic [PixelW-1:0] p);
    pixel_item_t it;
    it.kind  = KindLoad;
    it.pixel = p;
    pixel_items_pending.push_back(it);
  endtask

  // Reads carry random filler in the unused pixel field
  task automatic push_read();
    pixel_item_t it;
    it.kind  = KindRead;
    it.pixel = $urandom;
    pixel_items_pending.push_back(it);
  endtask

  function automatic logic [PixelW-1:0] random_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Mostly small sides, now and then the largest or out of range
  function automatic logic [CfgW-1:0] pick_side();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return CfgW'($urandom_range(1, 6));
    if (sel < 17) return CfgW'($urandom_range(7, 24));
    if (sel == 17) return '0;
    if (sel == 18) return CfgW'($urandom_range(MaxSide + 1, 127));
    return CfgW'(MaxSide);
  endfunction

  // Register write at one edge, enable dropped at the next
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WIDTH:  width_reg = val;
      CFG_HEIGHT: height_reg = val;
      CFG_MODE:   mode_reg = rot_mode_e'(val[1:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Idle: nothing queued or on the bus, every pixel back, plus settle time
  task automatic wait_idle();
    @(negedge clk_i);
    while (pixel_items_pending.size() != 0 || in_valid || rotated_pixels_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    phases_run++;
  endtask

  // One frame: loads then reads, with stray early reads and extra loads;
  // a truncated frame leaves the counters mid-frame for the next setting
  task automatic queue_frame(input int unsigned total, input bit truncate,
                             output int unsigned n_good);
    int unsigned stop, k;
    stop   = truncate ? $urandom_range(0, 2 * total - 1) : 2 * total;
    n_good = 0;
    for (k = 0; k < stop; k++) begin
      if (k < total) begin
        if ($urandom_range(0, 15) == 0) push_read();
        push_load(random_pixel());
      end else begin
        if ($urandom_range(0, 19) == 0) push_load(random_pixel());
        push_read();
      end
      n_good++;
    end
  endtask

  initial begin : stimulus
    int unsigned     good_items;
    int unsigned     n;
    logic [CfgW-1:0] raw_w, raw_h;
    good_items = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting 1x1: early read, one load, extra load ignored, read, early read
    push_read();
    push_load('0);
    push_load('1);
    push_read();
    push_read();
    wait_idle();

    // Spare index ignored; 3x2 rotated 90 with an early read mid-load
    write_reg(CfgIdxSpare, '1);
    write_reg(CFG_WIDTH, CfgW'(3));
    write_reg(CFG_HEIGHT, CfgW'(2));
    write_reg(CFG_MODE, CfgW'(ROT_90));
    push_load(32'h0000_0011);
    push_load(32'h0000_0012);
    push_load(32'hFFFF_FF13);
    push_read();
    push_load(32'h8000_0021);
    push_load(32'h7FFF_FF22);
    push_load(32'hA5A5_5A23);
    repeat (6) push_read();
    wait_idle();

    // Setting changed mid-frame: 2x2 at 180, half read, then 1x2 at 270
    write_reg(CFG_WIDTH, CfgW'(2));
    write_reg(CFG_MODE, CfgW'(ROT_180));
    push_load(32'hC0DE_0000);
    push_load(32'hC0DE_0001);
    push_load(32'hC0DE_0010);
    push_load(32'hC0DE_0011);
    push_read();
    push_read();
    wait_idle();
    write_reg(CFG_WIDTH, CfgW'(1));
    write_reg(CFG_MODE, CfgW'(ROT_270));
    push_read();
    wait_idle();

    // Out-of-range sides: clamp to 64x1 and 1x64
    write_reg(CFG_WIDTH, '1);
    write_reg(CFG_HEIGHT, '0);
    write_reg(CFG_MODE, CfgW'(ROT_90));
    queue_frame(MaxSide, 1'b0, n);
    good_items += n;
    wait_idle();
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_HEIGHT, '1);
    write_reg(CFG_MODE, CfgW'(ROT_0));
    queue_frame(MaxSide, 1'b0, n);
    good_items += n;
    wait_idle();

    // Random settings and frames
    while (good_items < RandomItems) begin
      raw_w = pick_side();
      raw_h = pick_side();
      if (side_len(raw_w) * side_len(raw_h) > AreaCap) raw_h = CfgW'($urandom_range(1, 4));
      in_burst  = ($urandom_range(0, 4) == 0);
      out_burst = ($urandom_range(0, 4) == 0);
      write_reg(CFG_WIDTH, raw_w);
      write_reg(CFG_HEIGHT, raw_h);
      write_reg(CFG_MODE, CfgW'($urandom_range(0, 3)));
      queue_frame(side_len(raw_w) * side_len(raw_h), $urandom_range(0, 7) == 0, n);
      good_items += n;
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (rotated_pixels_due.size() != 0)
      flag_mismatch($sformatf("%0d expected pixels never came out", rotated_pixels_due.size()));
    $display("ran %0d phases: %0d loads and %0d reads accepted", phases_run, loads_taken,
             reads_taken);
    $display("checked %0d rotated pixels over %0d complete frames, %0d mismatches",
             pixels_checked, frames_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_image_rotator_right_angles_top passed");
    end else begin
      $display("tb_image_rotator_right_angles_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rir_pkg.sv
src/rir_in_if.sv
src/rir_out_if.sv
src/rir_ram.sv
src/rir_ctrl.sv
src/rir_datapath.sv
src/image_rotator_right_angles_top.sv
sim/tb_image_rotator_right_angles_top.sv
